// ===== hw/rtl/fqba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqba_pkg: shared types and constants
// Widths, block geometry, command and status codes, and controller states
// for the free-queue / bump allocator.
// ----------------------------------------------------------------------------
package fqba_pkg;

	localparam int ADDR_W      = 48;
	localparam int SIZE_W      = 48;
	localparam int KEY_W       = 32;
	localparam int WM_W        = 30;
	localparam int BLK_SHIFT   = 21;                    // block is 2 MiB
	localparam int QUEUE_DEPTH = 256;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;
	localparam int NBLK_W      = SIZE_W - BLK_SHIFT;    // block count of a size

	localparam logic [SIZE_W-1:0] BLOCK_BYTES = SIZE_W'(1) << BLK_SHIFT;
	localparam logic [WM_W-1:0]   WM_RESET    = WM_W'(536870912);

	typedef enum logic [1:0] {
		CMD_INIT  = 2'd0,
		CMD_FETCH = 2'd1,
		CMD_FILL  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_BAD_SIZE = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INIT,
		S_START,
		S_PUSH,
		S_POP,
		S_CARVE
	} state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [KEY_W-1:0]  key;
	} q_entry_t;

endpackage

// ===== hw/rtl/free_queue_bump_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_queue_bump_allocator: remote-memory block allocator
// FIFO of free fixed-size blocks (address, key) in a synchronous RAM, backed
// by a bump region; init, fetch and fill commands.
// ----------------------------------------------------------------------------
// Usage:
//  - Command channel: start/busy. A word (cmd, addr, size, key) is taken at
//    a rising edge with start high and busy low.
//  - Result channel: done strobes for one cycle with status, out_addr and
//    out_key. The receiver cannot stall; every result is taken as shown.
//  - Config channel: cfg_valid/cfg_ready/cfg_data writes cache_watermark.
//    cfg_ready is always high; write only while the block is idle.
// Sequencing (accept to done; busy holds off the next command until done):
//  - errors, bump fetch, empty fill, unknown cmd: result registered at accept
//  - fetch popped from queue: registered RAM read, then result register in S_POP
//  - fetch carved from the raw region: decrement, then address add
//  - fill of n blocks: one RAM write per block in S_PUSH
//  - init preloading n blocks: remaining size, start address, then pushes
//  The queue RAM write port sets the fill/init rate at one block per cycle.
// Reset: queue empty, raw region zero, watermark 512 MiB. No clearing pass;
// queue RAM contents are only read inside the live count.
// ----------------------------------------------------------------------------
module free_queue_bump_allocator
	import fqba_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        cmd,
	input  logic [ADDR_W-1:0] addr,
	input  logic [SIZE_W-1:0] size,
	input  logic [KEY_W-1:0]  key,
	output logic              done,
	output logic [1:0]        status,
	output logic [ADDR_W-1:0] out_addr,
	output logic [KEY_W-1:0]  out_key,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [WM_W-1:0]   cfg_data
);

	state_t state_q, state_d;

	// queue RAM
	q_entry_t qmem [QUEUE_DEPTH];
	q_entry_t rd_q;
	logic     mem_we, mem_re;

	logic [QPTR_W-1:0] head_q, tail_q;
	logic [QCNT_W-1:0] count_q;

	// raw (bump) region
	logic [ADDR_W-1:0] raw_base_q;
	logic [SIZE_W-1:0] raw_rem_q;
	logic [KEY_W-1:0]  raw_key_q;
	logic [WM_W-1:0]   wm_q;

	// push sequencer
	logic [ADDR_W-1:0] push_addr_q;
	logic [KEY_W-1:0]  push_key_q;
	logic [QCNT_W-1:0] push_left_q;
	logic [SIZE_W-1:0] op_size_q;

	// result register
	logic              done_q;
	status_t           status_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [KEY_W-1:0]  out_key_q;

	// command decode
	cmd_t              cmd_c;
	logic              acc;
	logic              size_ok, is_blk, q_nonempty, raw_has_blk, bump_fits;
	logic [SIZE_W-1:0] cache;
	logic [NBLK_W-1:0] init_nraw, fill_n;
	logic [QCNT_W-1:0] init_n, q_free;
	logic              fill_fits;

	always_comb begin
		cmd_c       = cmd_t'(cmd);
		acc         = start && (state_q == S_IDLE);
		size_ok     = (size[BLK_SHIFT-1:0] == '0);
		is_blk      = (size == BLOCK_BYTES);
		q_nonempty  = (count_q != '0);
		raw_has_blk = (raw_rem_q >= BLOCK_BYTES);
		bump_fits   = (size <= raw_rem_q);
		cache       = (SIZE_W'(wm_q) < size) ? SIZE_W'(wm_q) : size;
		init_nraw   = cache[SIZE_W-1:BLK_SHIFT];
		// watermark can cover more blocks than the queue holds
		init_n      = (init_nraw > NBLK_W'(QUEUE_DEPTH)) ? QCNT_W'(QUEUE_DEPTH)
		                                                 : init_nraw[QCNT_W-1:0];
		fill_n      = size[SIZE_W-1:BLK_SHIFT];
		q_free      = QCNT_W'(QUEUE_DEPTH) - count_q;
		fill_fits   = (fill_n <= NBLK_W'(q_free));
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					unique case (cmd_c)
						CMD_INIT: begin
							if (size_ok) state_d = S_INIT;
						end
						CMD_FETCH: begin
							if (is_blk && q_nonempty) state_d = S_POP;
							else if (is_blk && raw_has_blk) state_d = S_CARVE;
						end
						CMD_FILL: begin
							if (size_ok && fill_fits && (fill_n != '0)) state_d = S_PUSH;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_INIT:  state_d = S_START;
			S_START: state_d = (push_left_q == '0) ? S_IDLE : S_PUSH;
			S_PUSH:  state_d = (push_left_q == QCNT_W'(1)) ? S_IDLE : S_PUSH;
			S_POP:   state_d = S_IDLE;
			S_CARVE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs / strobes
	always_comb begin
		busy      = (state_q != S_IDLE);
		cfg_ready = 1'b1;
		mem_we    = (state_q == S_PUSH);
		mem_re    = acc && (cmd_c == CMD_FETCH) && is_blk && q_nonempty;
	end

	assign done     = done_q;
	assign status   = status_q;
	assign out_addr = out_addr_q;
	assign out_key  = out_key_q;

	// queue RAM: one write, one registered read
	always_ff @(posedge clk) begin
		if (mem_we) qmem[tail_q] <= '{addr: push_addr_q, key: push_key_q};
		if (mem_re) rd_q <= qmem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			raw_base_q  <= '0;
			raw_rem_q   <= '0;
			raw_key_q   <= '0;
			wm_q        <= WM_RESET;
			push_addr_q <= '0;
			push_key_q  <= '0;
			push_left_q <= '0;
			op_size_q   <= '0;
			done_q      <= 1'b0;
			status_q    <= ST_OK;
			out_addr_q  <= '0;
			out_key_q   <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (cfg_valid && cfg_ready) wm_q <= cfg_data;

			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						// default result: ok with zero payload
						status_q   <= ST_OK;
						out_addr_q <= '0;
						out_key_q  <= '0;
						case (cmd_c)
							CMD_INIT: begin
								if (!size_ok) begin
									done_q   <= 1'b1;
									status_q <= ST_BAD_SIZE;
								end else begin
									head_q      <= '0;
									tail_q      <= '0;
									count_q     <= '0;
									raw_base_q  <= addr;
									raw_key_q   <= key;
									push_key_q  <= key;
									push_left_q <= init_n;
									op_size_q   <= size;
								end
							end
							CMD_FETCH: begin
								if (is_blk) begin
									if (q_nonempty) begin
										head_q  <= head_q + QPTR_W'(1);
										count_q <= count_q - QCNT_W'(1);
									end else if (raw_has_blk) begin
										raw_rem_q <= raw_rem_q - BLOCK_BYTES;
									end else begin
										done_q   <= 1'b1;
										status_q <= ST_NO_SPACE;
									end
								end else if (bump_fits) begin
									done_q     <= 1'b1;
									out_addr_q <= raw_base_q;
									out_key_q  <= raw_key_q;
									raw_base_q <= raw_base_q + size;
									raw_rem_q  <= raw_rem_q - size;
								end else begin
									done_q   <= 1'b1;
									status_q <= ST_NO_SPACE;
								end
							end
							CMD_FILL: begin
								if (!size_ok) begin
									done_q   <= 1'b1;
									status_q <= ST_BAD_SIZE;
								end else if (!fill_fits) begin
									done_q   <= 1'b1;
									status_q <= ST_FULL;
								end else if (fill_n == '0) begin
									done_q <= 1'b1;
								end else begin
									push_addr_q <= addr;
									push_key_q  <= key;
									push_left_q <= fill_n[QCNT_W-1:0];
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_INIT: begin
					raw_rem_q <= op_size_q - (SIZE_W'(push_left_q) << BLK_SHIFT);
				end
				S_START: begin
					// preloaded blocks sit at the top of the heap
					push_addr_q <= raw_base_q + raw_rem_q;
					if (push_left_q == '0) begin
						done_q <= 1'b1;
					end
				end
				S_PUSH: begin
					tail_q      <= tail_q + QPTR_W'(1);
					count_q     <= count_q + QCNT_W'(1);
					push_addr_q <= push_addr_q + BLOCK_BYTES;
					push_left_q <= push_left_q - QCNT_W'(1);
					if (push_left_q == QCNT_W'(1)) begin
						done_q <= 1'b1;
					end
				end
				S_POP: begin
					done_q     <= 1'b1;
					out_addr_q <= rd_q.addr;
					out_key_q  <= rd_q.key;
				end
				S_CARVE: begin
					// remaining already lowered by one block: top block address
					done_q     <= 1'b1;
					out_addr_q <= raw_base_q + raw_rem_q;
					out_key_q  <= raw_key_q;
				end
				default: begin
					done_q <= 1'b0;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count above depth");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == QCNT_W'(QUEUE_DEPTH)) |-> head_q == tail_q)
		else $error("head/tail disagree with count");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> count_q < QCNT_W'(QUEUE_DEPTH))
		else $error("push into full queue");

	a_pop_done: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |=> (state_q == S_POP) ##1 done)
		else $error("queue pop did not produce a result");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

endmodule
